>>> rtl/clpd_pkg.sv
// Shared types and constants for the calibrated light presence detector.
package clpd_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned M_TDATA_W = 24;

    // Register indexes on the configuration channel.
    typedef enum logic [IDX_W-1:0] {
        REG_BAND_MARGIN      = 3'd0,
        REG_BASELINE_CEILING = 3'd1,
        REG_CAL_SAMPLES      = 3'd2,
        REG_SCORE_LIMIT      = 3'd3,
        REG_SCORE_START      = 3'd4
    } reg_idx_t;

    localparam logic [DATA_W-1:0] RST_BAND_MARGIN      = 8'd5;
    localparam logic [DATA_W-1:0] RST_BASELINE_CEILING = 8'd249;
    localparam logic [DATA_W-1:0] RST_CAL_SAMPLES      = 8'd254;
    localparam logic [DATA_W-1:0] RST_SCORE_LIMIT      = 8'd100;
    localparam logic [DATA_W-1:0] RST_SCORE_START      = 8'd50;

    typedef struct packed {
        logic [DATA_W-1:0] band_margin;
        logic [DATA_W-1:0] baseline_ceiling;
        logic [DATA_W-1:0] calibration_samples;
        logic [DATA_W-1:0] score_limit;
        logic [DATA_W-1:0] score_start;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] light_level;
        logic              calibrating;
        logic [DATA_W-1:0] score_now;
        logic              lamp_on;
    } result_t;

endpackage

>>> rtl/clpd_cfg_regs.sv
// Configuration register file for the light presence detector.
module clpd_cfg_regs
    import clpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_BAND_MARGIN:      cfg_next.band_margin         = cfg_data;
                REG_BASELINE_CEILING: cfg_next.baseline_ceiling    = cfg_data;
                REG_CAL_SAMPLES:      cfg_next.calibration_samples = cfg_data;
                REG_SCORE_LIMIT:      cfg_next.score_limit         = cfg_data;
                REG_SCORE_START:      cfg_next.score_start         = cfg_data;
                default:              cfg_next = cfg_reg; // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.band_margin         <= RST_BAND_MARGIN;
            cfg_reg.baseline_ceiling    <= RST_BASELINE_CEILING;
            cfg_reg.calibration_samples <= RST_CAL_SAMPLES;
            cfg_reg.score_limit         <= RST_SCORE_LIMIT;
            cfg_reg.score_start         <= RST_SCORE_START;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/clpd_core.sv
// Calibration / tracking state and the per-sample decision logic.
module clpd_core
    import clpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [DATA_W-1:0] adc_raw,
    input  cfg_t              cfg,
    output result_t           result
);

    logic              tracking_reg, tracking_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0] baseline_reg, baseline_next;
    logic [DATA_W-1:0] score_reg, score_next;
    logic              lamp_reg, lamp_next;

    logic [DATA_W-1:0] level;
    logic [DATA_W:0]   done;
    logic [DATA_W:0]   upper;
    logic [DATA_W:0]   level_plus_margin;
    logic              go_up;
    logic              go_down;

    always_comb begin
        level = ~adc_raw;
        done  = {1'b0, count_reg} + {{DATA_W{1'b0}}, 1'b1};
        upper = {1'b0, baseline_reg} + {1'b0, cfg.band_margin};
        // level < baseline - margin, kept non-negative
        level_plus_margin = {1'b0, level} + {1'b0, cfg.band_margin};
        go_up   = ({1'b0, level} > upper) && (score_reg < cfg.score_limit);
        go_down = (level_plus_margin < {1'b0, baseline_reg}) && (score_reg != '0);

        tracking_next = tracking_reg;
        count_next    = count_reg;
        baseline_next = baseline_reg;
        score_next    = score_reg;
        lamp_next     = lamp_reg;

        if (!tracking_reg) begin
            if (level > baseline_reg && level < cfg.baseline_ceiling)
                baseline_next = level;
            if (done >= {1'b0, cfg.calibration_samples}) begin
                tracking_next = 1'b1;
                count_next    = '0;
                score_next    = cfg.score_start;
            end else begin
                count_next = done[DATA_W-1:0];
            end
        end else begin
            if (go_up)
                score_next = score_reg + 8'd1;
            else if (go_down)
                score_next = score_reg - 8'd1;
            if (score_next == cfg.score_limit)
                lamp_next = 1'b1;
            if (score_next == '0)
                lamp_next = 1'b0;
        end

        result.light_level = level;
        result.calibrating = !tracking_reg;
        result.score_now   = score_next;
        result.lamp_on     = lamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg <= 1'b0;
            count_reg    <= '0;
            baseline_reg <= '0;
            score_reg    <= RST_SCORE_START;
            lamp_reg     <= 1'b0;
        end else if (advance) begin
            tracking_reg <= tracking_next;
            count_reg    <= count_next;
            baseline_reg <= baseline_next;
            score_reg    <= score_next;
            lamp_reg     <= lamp_next;
        end
    end

endmodule

>>> rtl/calibrated_light_presence_detector_unit.sv
// Top level of the calibrated light presence detector.
//
// Usage:
//   s_axis: one raw 8-bit converter sample per transaction (s_tdata[7:0]).
//   m_axis: one result per sample. m_tdata holds light level, score and lamp;
//           m_tuser flags a sample handled during calibration.
//   cfg:    register writes (index, data), always ready. Write only while the
//           block is idle; a write takes effect from the next sample.
// Timing: the sample is captured in an input register, the decision logic runs
//   between that register and the result register, and the detector state
//   updates as the result is loaded.
// Throughput: one sample per cycle while m_tready is high; the combinational
//   compare and saturating score update feed back into the state registers.
// Reset (aresetn low, synchronous): both pipeline stages empty, configuration
//   back to its defaults, detector restarts calibration with zero baseline.
// Stall: while m_tready is low a full result register holds; the input register
//   still takes one more sample, then s_tready drops until the result drains.
module calibrated_light_presence_detector_unit
    import clpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [7:0] adc_raw
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] light_level, [15:8] score_now,
                                            // [16] lamp_on, [23:17] zero
    output logic                 m_tuser,   // [0] calibrating
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_data_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic    advance;   // input register moves into result register
    logic    out_free;
    cfg_t    cfg;
    result_t result;

    assign cfg_ready = 1'b1;

    clpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .adc_raw (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Pipeline handshake: each stage loads when it is empty or drains this cycle.
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        advance        = in_valid_reg && out_free;
        s_tready       = !in_valid_reg || out_free;
        in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.lamp_on, out_reg.score_now, out_reg.light_level};
    assign m_tuser  = out_reg.calibrating;

`ifndef ASSERT_OFF
    // A lit lamp never goes with a zero score.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[15:8] != 8'd0)
        else $error("lamp lit with zero score");

    // The lamp cannot be lit during calibration.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[16])
        else $error("lamp lit during calibration");

    // Both stages full and receiver stalled: no new sample may be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted with pipeline full");

    // Once tracking, a result is never marked as calibrating again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |=> !(m_tvalid && m_tuser))
        else $error("return to calibration phase");
`endif

endmodule
